@@ sv/cspp_pkg.sv @@
// ============================================================================
// cspp_pkg
// Shared types and constants of the CAN signal pack/unpack core: operation
// codes, register indexes, descriptor field layout and sequencer states.
// ============================================================================
package cspp_pkg;

  // Default sizing
  localparam int NUM_SIGNALS_DEF = 4;
  localparam int FRAME_BYTES_DEF = 8;

  // Fixed widths of the item fields
  localparam int FRAME_W   = 64;
  localparam int VALUE_W   = 32;
  localparam int ID_W      = 16;
  localparam int SIG_ID_W  = 8;
  localparam int LEN_W     = 4;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 32;
  localparam int IN_DATA_W  = 136;
  localparam int OUT_DATA_W = 120;

  // Descriptor layout: id, start bit, size, big-endian flag
  localparam int DESC_W       = 21;
  localparam int DESC_REGS    = 4;
  localparam int DESC_ID_LSB  = 0;
  localparam int DESC_ST_LSB  = 8;
  localparam int DESC_SZ_LSB  = 14;
  localparam int DESC_BIG_BIT = 20;
  localparam int POS_W        = 6;
  localparam int SIZE_W       = 6;
  localparam logic [SIZE_W-1:0] MAX_SIZE = 6'd32;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SIGNAL_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DESC_BASE    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROUTE_IDS    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_RX_LENGTH    = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_TX_LENGTH    = 3'd7;

  localparam logic [LEN_W-1:0] LEN_RESET = 4'd8;

  typedef enum logic [1:0] {
    OP_RECEIVE = 2'd0,
    OP_READ    = 2'd1,
    OP_WRITE   = 2'd2,
    OP_SEND    = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_EXTRACT,
    ST_PREP,
    ST_ROT_MASK,
    ST_ROT_DATA,
    ST_DONE
  } state_t;

endpackage

@@ sv/cspp_rotator.sv @@
// ============================================================================
// cspp_rotator
// Left rotator over one frame of network bits, MSB first. The sequencer uses
// it both to bring a signal's first bit to the top and to place chunks back.
// ============================================================================
module cspp_rotator #(
  parameter int WIDTH = 64
) (
  input  logic [WIDTH-1:0]         data,
  input  logic [$clog2(WIDTH)-1:0] amt,
  output logic [WIDTH-1:0]         rotated
);

  logic [2*WIDTH-1:0] doubled;

  // Rotate by shifting two copies and keeping the upper half
  always_comb begin
    doubled = {data, data} << amt;
    rotated = doubled[2*WIDTH-1:WIDTH];
  end

endmodule

@@ sv/can_signal_pack_unpack_core.sv @@
// ============================================================================
// can_signal_pack_unpack_core
// Signal packer/unpacker over one receive frame and one transmit frame.
// ============================================================================
// Usage:
//   Input items arrive on s_tvalid/s_tready; s_tuser is the operation
//   (receive frame, read signal, write signal, send frame). Every item gives
//   exactly one result item on m_tvalid/m_tready.
//   Configuration is written through cfg_we/cfg_index/cfg_data while idle.
// Sequence:
//   Receive and send go from accept through ST_DONE to the output register.
//   Read and write first search the descriptors one per cycle (up to
//   NUM_SIGNALS of them); a read then passes ST_EXTRACT, a write ST_PREP and
//   one ST_ROT_MASK/ST_ROT_DATA pass of the shared frame rotator per chunk,
//   with ceil(size / (8*FRAME_BYTES)) passes (at most one for 8-byte frames).
//   Only one item is in work at a time; s_tready is high while idle.
// Reset:
//   rst clears both frames, the descriptors and routes, and sets both frame
//   lengths to 8. No clearing pass is needed.
// Stall:
//   A finished result waits in the output register; a new item can still
//   be accepted, and its result is held until the register frees up.
// ============================================================================
module can_signal_pack_unpack_core #(
  parameter int NUM_SIGNALS = cspp_pkg::NUM_SIGNALS_DEF,
  parameter int FRAME_BYTES = cspp_pkg::FRAME_BYTES_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  // Configuration writes
  input  logic                             cfg_we,
  input  logic [cspp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [cspp_pkg::CFG_W-1:0]       cfg_data,
  // Input items
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // pdu_id[15:0], payload_length[31:16], payload[95:32],
  // signal_id[103:96], signal_value[135:104]
  input  logic [cspp_pkg::IN_DATA_W-1:0]   s_tdata,
  // op[1:0]
  input  logic [1:0]                       s_tuser,
  // Result items
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // read_value[31:0], frame_route[47:32], frame_length[51:48],
  // frame_data[115:52], zero[119:116]
  output logic [cspp_pkg::OUT_DATA_W-1:0]  m_tdata,
  // status[0], frame_valid[1]
  output logic [1:0]                       m_tuser
);

  localparam int FrameBits = FRAME_BYTES * 8;
  localparam int RotW      = $clog2(FrameBits);
  localparam int CntW      = $clog2(NUM_SIGNALS + 1);
  localparam int IdxW      = (NUM_SIGNALS > 1) ? $clog2(NUM_SIGNALS) : 1;
  localparam int FW        = cspp_pkg::FRAME_W;
  localparam int VW        = cspp_pkg::VALUE_W;
  localparam logic [cspp_pkg::LEN_W-1:0] FbBytes = cspp_pkg::LEN_W'(FRAME_BYTES);
  localparam logic [3:0]  NumSig = 4'(NUM_SIGNALS);
  localparam logic [RotW:0] FbVal = (RotW + 1)'(FrameBits);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [2:0]                       signal_count;
  logic [cspp_pkg::CFG_W-1:0]       route_ids;
  logic [cspp_pkg::LEN_W-1:0]       rx_frame_length;
  logic [cspp_pkg::LEN_W-1:0]       tx_frame_length;
  logic [cspp_pkg::DESC_W-1:0]      desc [NUM_SIGNALS];

  always_ff @(posedge clk) begin
    if (rst) begin
      signal_count    <= '0;
      route_ids       <= '0;
      rx_frame_length <= cspp_pkg::LEN_RESET;
      tx_frame_length <= cspp_pkg::LEN_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        cspp_pkg::REG_SIGNAL_COUNT: signal_count    <= cfg_data[2:0];
        cspp_pkg::REG_ROUTE_IDS:    route_ids       <= cfg_data;
        cspp_pkg::REG_RX_LENGTH:    rx_frame_length <= cfg_data[cspp_pkg::LEN_W-1:0];
        cspp_pkg::REG_TX_LENGTH:    tx_frame_length <= cfg_data[cspp_pkg::LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // Descriptors beyond the writable ones stay zero
  for (genvar k = 0; k < NUM_SIGNALS; k++) begin : g_desc
    if (k < cspp_pkg::DESC_REGS) begin : g_reg
      logic [cspp_pkg::DESC_W-1:0] value;
      always_ff @(posedge clk) begin
        if (rst) begin
          value <= '0;
        end else if (cfg_we &&
                     cfg_index == cspp_pkg::REG_DESC_BASE + cspp_pkg::CFG_IDX_W'(k)) begin
          value <= cfg_data[cspp_pkg::DESC_W-1:0];
        end
      end
      assign desc[k] = value;
    end else begin : g_zero
      assign desc[k] = '0;
    end
  end

  // Start bit modulo frame bits, as a constant table
  logic [RotW-1:0] start_mod [64];
  for (genvar g = 0; g < 64; g++) begin : g_mod
    assign start_mod[g] = RotW'(g % FrameBits);
  end

  // --------------------------------------------------------------------------
  // State and item registers
  // --------------------------------------------------------------------------
  cspp_pkg::state_t state, state_next;

  cspp_pkg::op_t               op_q;
  logic [cspp_pkg::ID_W-1:0]   pdu_id_q;
  logic [15:0]                 plen_q;
  logic [FW-1:0]               payload_q;
  logic [cspp_pkg::SIG_ID_W-1:0] sig_id_q;
  logic [VW-1:0]               sig_val_q;

  logic [CntW-1:0]             idx;
  logic                        found;
  logic [RotW-1:0]             rot_amt_q;
  logic [cspp_pkg::SIZE_W-1:0] size_q;
  logic                        big_q;

  logic [FrameBits-1:0]        rx_frame;
  logic [FrameBits-1:0]        tx_frame;
  logic [FrameBits-1:0]        rot_q;
  logic [FrameBits-1:0]        mask_rot_q;
  logic [FW-1:0]               work_s;
  logic [FW-1:0]               work_m;

  // Search view
  logic [3:0]                  search_n;
  logic                        search_end;
  logic                        search_hit;
  logic [cspp_pkg::DESC_W-1:0] cur_desc;
  logic [cspp_pkg::POS_W-1:0]  cur_start;
  logic [cspp_pkg::SIZE_W-1:0] cur_size_raw;

  assign search_n   = ({1'b0, signal_count} > NumSig) ? NumSig : {1'b0, signal_count};
  assign search_end = 4'(idx) >= search_n;
  assign cur_desc   = desc[idx[IdxW-1:0]];
  assign search_hit = cur_desc[cspp_pkg::DESC_ID_LSB +: cspp_pkg::SIG_ID_W] == sig_id_q;
  assign cur_start  = cur_desc[cspp_pkg::DESC_ST_LSB +: cspp_pkg::POS_W];
  assign cur_size_raw = cur_desc[cspp_pkg::DESC_SZ_LSB +: cspp_pkg::SIZE_W];

  // --------------------------------------------------------------------------
  // Shared rotator and its input selection
  // --------------------------------------------------------------------------
  logic [FrameBits-1:0] rot_in;
  logic [RotW-1:0]      rot_sel;
  logic [FrameBits-1:0] rot_out;
  logic [RotW-1:0]      place_amt;

  // Placing a chunk is a right rotate by start, done as a left rotate
  assign place_amt = (rot_amt_q == '0) ? '0 : RotW'(FbVal - {1'b0, rot_amt_q});

  always_comb begin
    rot_in  = rx_frame;
    rot_sel = rot_amt_q;
    case (state)
      cspp_pkg::ST_ROT_MASK: begin
        rot_in  = work_m[FW-1 -: FrameBits];
        rot_sel = place_amt;
      end
      cspp_pkg::ST_ROT_DATA: begin
        rot_in  = work_s[FW-1 -: FrameBits];
        rot_sel = place_amt;
      end
      default: ;
    endcase
  end

  cspp_rotator #(
    .WIDTH (FrameBits)
  ) u_rotator (
    .data    (rot_in),
    .amt     (rot_sel),
    .rotated (rot_out)
  );

  // --------------------------------------------------------------------------
  // Value alignment
  // --------------------------------------------------------------------------
  logic [VW-1:0] window;
  logic [VW-1:0] window_rev;
  logic [VW-1:0] val_rev;
  logic [VW-1:0] read_big;
  logic [VW-1:0] read_little;
  logic [VW-1:0] seq_s;
  logic [VW-1:0] seq_m;

  // Network bits of the signal, first bit at the MSB, repeating on wrap
  for (genvar i = 0; i < VW; i++) begin : g_win
    assign window[VW-1-i]   = rot_q[FrameBits-1-(i % FrameBits)];
    assign window_rev[i]    = window[VW-1-i];
    assign val_rev[VW-1-i]  = sig_val_q[i];
  end

  assign read_big    = window >> (6'(VW) - size_q);
  assign read_little = window_rev & ~({VW{1'b1}} << size_q);
  assign seq_s       = big_q ? (sig_val_q << (6'(VW) - size_q)) : val_rev;
  assign seq_m       = ~({VW{1'b1}} >> size_q);

  // --------------------------------------------------------------------------
  // Frame masks and result fields
  // --------------------------------------------------------------------------
  function automatic logic [FrameBits-1:0] bytes_mask(input logic [3:0] n);
    logic [FrameBits-1:0] m;
    m = '0;
    for (int b = 0; b < FRAME_BYTES; b++) begin
      m[FrameBits-1-8*b -: 8] = (b < int'(n)) ? 8'hFF : 8'h00;
    end
    return m;
  endfunction

  logic [cspp_pkg::LEN_W-1:0] rx_cap;
  logic [cspp_pkg::LEN_W-1:0] tx_cap;
  logic [cspp_pkg::LEN_W-1:0] copy_n;
  logic [FrameBits-1:0]       copy_mask;
  logic                       route_hit;
  logic                       send_ok;
  logic                       out_free;
  logic [FW-1:0]              next_work_m;

  assign rx_cap    = (rx_frame_length > FbBytes) ? FbBytes : rx_frame_length;
  assign tx_cap    = (tx_frame_length > FbBytes) ? FbBytes : tx_frame_length;
  assign copy_n    = (plen_q < {12'b0, rx_cap}) ? plen_q[cspp_pkg::LEN_W-1:0] : rx_cap;
  assign copy_mask = bytes_mask(copy_n);
  assign route_hit = pdu_id_q == route_ids[cspp_pkg::ID_W-1:0];
  assign send_ok   = pdu_id_q == '0;
  assign out_free  = !m_tvalid || m_tready;
  assign next_work_m = work_m << FrameBits;

  // --------------------------------------------------------------------------
  // Sequencer: next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_next = state;
    case (state)
      cspp_pkg::ST_IDLE: begin
        if (s_tvalid) begin
          if (s_tuser == cspp_pkg::OP_READ || s_tuser == cspp_pkg::OP_WRITE) begin
            state_next = cspp_pkg::ST_SEARCH;
          end else begin
            state_next = cspp_pkg::ST_DONE;
          end
        end
      end
      cspp_pkg::ST_SEARCH: begin
        if (search_end) begin
          state_next = cspp_pkg::ST_DONE;
        end else if (search_hit) begin
          state_next = (op_q == cspp_pkg::OP_READ) ? cspp_pkg::ST_EXTRACT : cspp_pkg::ST_PREP;
        end
      end
      cspp_pkg::ST_EXTRACT: state_next = cspp_pkg::ST_DONE;
      cspp_pkg::ST_PREP: begin
        state_next = (size_q == '0) ? cspp_pkg::ST_DONE : cspp_pkg::ST_ROT_MASK;
      end
      cspp_pkg::ST_ROT_MASK: state_next = cspp_pkg::ST_ROT_DATA;
      cspp_pkg::ST_ROT_DATA: begin
        state_next = (next_work_m == '0) ? cspp_pkg::ST_DONE : cspp_pkg::ST_ROT_MASK;
      end
      cspp_pkg::ST_DONE: begin
        if (out_free) begin
          state_next = cspp_pkg::ST_IDLE;
        end
      end
      default: state_next = cspp_pkg::ST_IDLE;
    endcase
  end

  // Sequencer: outputs
  always_comb begin
    s_tready = 1'b0;
    case (state)
      cspp_pkg::ST_IDLE: s_tready = 1'b1;
      default:           s_tready = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cspp_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // --------------------------------------------------------------------------
  // Datapath
  // --------------------------------------------------------------------------
  // Latch the item and run the search
  always_ff @(posedge clk) begin
    if (rst) begin
      idx   <= '0;
      found <= 1'b0;
    end else begin
      case (state)
        cspp_pkg::ST_IDLE: begin
          idx   <= '0;
          found <= 1'b0;
        end
        cspp_pkg::ST_SEARCH: begin
          if (!search_end) begin
            if (search_hit) begin
              found <= 1'b1;
            end else begin
              idx <= idx + 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == cspp_pkg::ST_IDLE && s_tvalid) begin
      op_q      <= cspp_pkg::op_t'(s_tuser);
      pdu_id_q  <= s_tdata[15:0];
      plen_q    <= s_tdata[31:16];
      payload_q <= s_tdata[95:32];
      sig_id_q  <= s_tdata[103:96];
      sig_val_q <= s_tdata[135:104];
    end
    // Decode the matching descriptor
    if (state == cspp_pkg::ST_SEARCH && !search_end && search_hit) begin
      rot_amt_q <= start_mod[cur_start];
      size_q    <= (cur_size_raw > cspp_pkg::MAX_SIZE) ? cspp_pkg::MAX_SIZE : cur_size_raw;
      big_q     <= cur_desc[cspp_pkg::DESC_BIG_BIT];
    end
    // Bring the signal's first bit to the top of the frame
    if (state == cspp_pkg::ST_EXTRACT) begin
      rot_q <= rot_out;
    end
    // Load value and mask in network order, then advance one chunk per pass
    if (state == cspp_pkg::ST_PREP) begin
      work_s <= {seq_s, {(FW - VW){1'b0}}};
      work_m <= {seq_m, {(FW - VW){1'b0}}};
    end else if (state == cspp_pkg::ST_ROT_DATA) begin
      work_s <= work_s << FrameBits;
      work_m <= next_work_m;
    end
    if (state == cspp_pkg::ST_ROT_MASK) begin
      mask_rot_q <= rot_out;
    end
  end

  // Frames
  always_ff @(posedge clk) begin
    if (rst) begin
      rx_frame <= '0;
      tx_frame <= '0;
    end else begin
      if (state == cspp_pkg::ST_DONE && out_free && op_q == cspp_pkg::OP_RECEIVE && route_hit) begin
        rx_frame <= (rx_frame & ~copy_mask) | (payload_q[FW-1 -: FrameBits] & copy_mask);
      end
      if (state == cspp_pkg::ST_ROT_DATA) begin
        tx_frame <= (tx_frame & ~mask_rot_q) | (rot_out & mask_rot_q);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  logic                       res_status;
  logic [VW-1:0]              res_value;
  logic                       res_fvalid;
  logic [cspp_pkg::ID_W-1:0]  res_route;
  logic [cspp_pkg::LEN_W-1:0] res_len;
  logic [FW-1:0]              res_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == cspp_pkg::ST_DONE && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == cspp_pkg::ST_DONE && out_free) begin
      res_status <= 1'b1;
      res_value  <= '0;
      res_fvalid <= 1'b0;
      res_route  <= '0;
      res_len    <= '0;
      res_data   <= '0;
      case (op_q)
        cspp_pkg::OP_RECEIVE: res_status <= !route_hit;
        cspp_pkg::OP_READ: begin
          res_status <= !found;
          if (found) begin
            res_value <= big_q ? read_big : read_little;
          end
        end
        cspp_pkg::OP_WRITE: res_status <= !found;
        cspp_pkg::OP_SEND: begin
          res_status <= !send_ok;
          if (send_ok) begin
            res_fvalid <= 1'b1;
            res_route  <= route_ids[cspp_pkg::CFG_W-1 -: cspp_pkg::ID_W];
            res_len    <= tx_cap;
            res_data   <= FW'(tx_frame & bytes_mask(tx_cap)) << (FW - FrameBits);
          end
        end
        default: ;
      endcase
    end
  end

  assign m_tdata = {4'b0, res_data, res_len, res_route, res_value};
  assign m_tuser = {res_fvalid, res_status};

endmodule

@@ tb/sv/can_signal_pack_unpack_core_tb.sv @@
// ============================================================================
// can_signal_pack_unpack_core_tb
// Self-checking bench for the CAN signal pack/unpack core. A scoreboard keeps
// its own copy of the descriptors, routes and both frames, predicts one
// result per accepted input item and checks every result item in order.
// Stimulus is a short directed run over the special cases, then random
// phases with fresh register settings and varying idle/stall pressure.
// ============================================================================
module can_signal_pack_unpack_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import cspp_pkg::*;

  localparam int WATCHDOG_LIMIT  = 5000;
  localparam int NUM_PHASES      = 8;
  localparam int ITEMS_PER_PHASE = 110;
  localparam int LONG_HOLD       = 300;

  typedef struct packed {
    logic              status;
    logic [VALUE_W-1:0] read_value;
    logic              frame_valid;
    logic [ID_W-1:0]   frame_route;
    logic [LEN_W-1:0]  frame_length;
    logic [FRAME_W-1:0] frame_data;
  } frame_result_t;

  // --------------------------------------------------------------------------
  // Scoreboard: predicts the result of each item and checks results in order
  // --------------------------------------------------------------------------
  class frame_scoreboard;
    logic [2:0]        sig_count;
    logic [DESC_W-1:0] sig_desc [DESC_REGS];
    logic [31:0]       routes;
    logic [LEN_W-1:0]  rx_len;
    logic [LEN_W-1:0]  tx_len;
    logic [63:0]       rx_frame;
    logic [63:0]       tx_frame;
    frame_result_t     expected_q [$];
    int                errors;

    function void clear();
      sig_count = '0;
      foreach (sig_desc[i]) sig_desc[i] = '0;
      routes   = '0;
      rx_len   = LEN_RESET;
      tx_len   = LEN_RESET;
      rx_frame = '0;
      tx_frame = '0;
      expected_q.delete();
      errors   = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
      if (idx == REG_SIGNAL_COUNT) sig_count = val[2:0];
      else if (idx == REG_ROUTE_IDS) routes = val;
      else if (idx == REG_RX_LENGTH) rx_len = val[LEN_W-1:0];
      else if (idx == REG_TX_LENGTH) tx_len = val[LEN_W-1:0];
      else sig_desc[idx - REG_DESC_BASE] = val[DESC_W-1:0];
    endfunction

    // bytes 0..n-1 of the frame word, byte 0 on top
    function logic [63:0] byte_mask(int n);
      if (n <= 0) return '0;
      if (n >= 8) return '1;
      return ~({64{1'b1}} >> (n * 8));
    endfunction

    function int cap_len(logic [LEN_W-1:0] n);
      return (n > FRAME_BYTES_DEF) ? FRAME_BYTES_DEF : int'(n);
    endfunction

    // first matching descriptor among the searched ones, -1 if none
    function int find_desc(logic [SIG_ID_W-1:0] id);
      int n;
      n = (sig_count > DESC_REGS) ? DESC_REGS : int'(sig_count);
      for (int s = 0; s < n; s++)
        if (sig_desc[s][7:0] == id) return s;
      return -1;
    endfunction

    function int field_size(logic [DESC_W-1:0] d);
      return (d[19:14] > MAX_SIZE) ? int'(MAX_SIZE) : int'(d[19:14]);
    endfunction

    // network bit p sits at word bit 63-p, positions wrap at 64
    function logic [VALUE_W-1:0] extract_field(logic [63:0] frame, logic [DESC_W-1:0] d);
      logic [VALUE_W-1:0] v;
      int size;
      int pos;
      v = '0;
      size = field_size(d);
      for (int i = 0; i < size; i++) begin
        pos = (int'(d[13:8]) + i) % 64;
        if (d[DESC_BIG_BIT]) v = {v[VALUE_W-2:0], frame[63 - pos]};
        else v[i] = frame[63 - pos];
      end
      return v;
    endfunction

    function logic [63:0] insert_field(logic [63:0] frame, logic [DESC_W-1:0] d,
                                       logic [VALUE_W-1:0] v);
      int size;
      int pos;
      size = field_size(d);
      for (int i = 0; i < size; i++) begin
        pos = (int'(d[13:8]) + i) % 64;
        frame[63 - pos] = d[DESC_BIG_BIT] ? v[size - 1 - i] : v[i];
      end
      return frame;
    endfunction

    function void note_input(op_t op, logic [IN_DATA_W-1:0] d);
      logic [15:0]  pdu;
      logic [15:0]  plen;
      logic [63:0]  payload;
      logic [7:0]   sid;
      logic [31:0]  sval;
      logic [63:0]  m;
      frame_result_t r;
      int s;
      int n;
      pdu     = d[15:0];
      plen    = d[31:16];
      payload = d[95:32];
      sid     = d[103:96];
      sval    = d[135:104];
      r = '0;
      r.status = 1'b1;
      case (op)
        OP_RECEIVE: begin
          if (pdu == routes[15:0]) begin
            n = cap_len(rx_len);
            if (int'(plen) < n) n = int'(plen);
            m = byte_mask(n);
            rx_frame = (rx_frame & ~m) | (payload & m);
            r.status = 1'b0;
          end
        end
        OP_READ: begin
          s = find_desc(sid);
          if (s >= 0) begin
            r.read_value = extract_field(rx_frame, sig_desc[s]);
            r.status = 1'b0;
          end
        end
        OP_WRITE: begin
          s = find_desc(sid);
          if (s >= 0) begin
            tx_frame = insert_field(tx_frame, sig_desc[s], sval);
            r.status = 1'b0;
          end
        end
        default: begin
          if (pdu == '0) begin
            n = cap_len(tx_len);
            r.frame_length = n[LEN_W-1:0];
            r.frame_data   = tx_frame & byte_mask(n);
            r.frame_route  = routes[31:16];
            r.frame_valid  = 1'b1;
            r.status       = 1'b0;
          end
        end
      endcase
      expected_q.push_back(r);
    endfunction

    function void compare_field(string name, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
        $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(logic [OUT_DATA_W-1:0] td, logic [1:0] tu);
      frame_result_t want;
      if (expected_q.size() == 0) begin
        $error("result item with no prediction pending: tdata 0x%0h tuser %0b", td, tu);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      compare_field("status", 64'(want.status), 64'(tu[0]));
      compare_field("frame_valid", 64'(want.frame_valid), 64'(tu[1]));
      compare_field("read_value", 64'(want.read_value), 64'(td[31:0]));
      compare_field("frame_route", 64'(want.frame_route), 64'(td[47:32]));
      compare_field("frame_length", 64'(want.frame_length), 64'(td[51:48]));
      compare_field("frame_data", want.frame_data, td[115:52]);
      compare_field("tdata_pad", 64'd0, 64'(td[119:116]));
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Signals and DUT
  // --------------------------------------------------------------------------
  logic                  clk;
  logic                  rst       = 1'b1;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_W-1:0]      cfg_data  = '0;
  logic                  s_tvalid  = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata   = '0;
  logic [1:0]            s_tuser   = '0;
  logic                  m_tvalid;
  logic                  m_tready  = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic [1:0]            m_tuser;

  frame_scoreboard board;
  logic [CFG_W-1:0] cfg_vals [8];
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_cycles    = 0;

  can_signal_pack_unpack_core dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Receiver: check accepted results, then pick next ready (hold or random)
  // --------------------------------------------------------------------------
  initial begin
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid && m_tready) board.check_result(m_tdata, m_tuser);
      if (hold_cycles > 0) begin
        m_tready <= 1'b0;
        hold_cycles--;
      end else begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: stop when nothing is accepted for too long
  // --------------------------------------------------------------------------
  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet = 0;
      else quiet++;
      if (quiet >= WATCHDOG_LIMIT) begin
        $display("can_signal_pack_unpack_core_tb: FAIL");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Driver tasks
  // --------------------------------------------------------------------------
  // offer one item and return at the edge where it is taken; valid stays high
  task automatic push_item(input op_t op, input logic [15:0] pdu, input logic [15:0] plen,
                           input logic [63:0] payload, input logic [7:0] sid,
                           input logic [31:0] sval);
    logic [IN_DATA_W-1:0] d;
    d = {sval, sid, payload, plen, pdu};
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= d;
    s_tuser  <= op;
    do @(posedge clk); while (!s_tready);
    board.note_input(op, d);
  endtask

  // lower valid and wait until every predicted result has come back
  task automatic drain();
    s_tvalid <= 1'b0;
    while (board.expected_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic program_regs();
    for (int i = REG_SIGNAL_COUNT; i <= REG_TX_LENGTH; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= i[CFG_IDX_W-1:0];
      cfg_data  <= cfg_vals[i];
      board.write_reg(i[CFG_IDX_W-1:0], cfg_vals[i]);
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [CFG_W-1:0] make_desc(logic [7:0] id, logic [5:0] start,
                                                 logic [5:0] size, logic big);
    return {11'd0, big, size, start, id};
  endfunction

  // random settings; some phases force the extremes
  function automatic void pick_config(int phase);
    logic [7:0] id;
    logic [5:0] size;
    int r;
    id = 8'($urandom_range(255));
    for (int k = 0; k < DESC_REGS; k++) begin
      if ($urandom_range(99) >= 20) id = 8'($urandom_range(255));
      r = $urandom_range(99);
      if (r < 80) size = 6'($urandom_range(32, 1));
      else if (r < 90) size = '0;
      else size = 6'($urandom_range(63, 33));
      cfg_vals[REG_DESC_BASE + k] =
        make_desc(id, 6'($urandom_range(63)), size, 1'($urandom_range(1)));
    end
    cfg_vals[REG_SIGNAL_COUNT] = ($urandom_range(99) < 70) ? 32'(DESC_REGS)
                                                           : 32'($urandom_range(7));
    cfg_vals[REG_ROUTE_IDS] = $urandom();
    cfg_vals[REG_RX_LENGTH] = ($urandom_range(1)) ? 32'(LEN_RESET) : 32'($urandom_range(15));
    cfg_vals[REG_TX_LENGTH] = ($urandom_range(1)) ? 32'(LEN_RESET) : 32'($urandom_range(15));
    case (phase)
      1: begin
        cfg_vals[REG_SIGNAL_COUNT] = 32'd7;
        cfg_vals[REG_RX_LENGTH]    = 32'd15;
        cfg_vals[REG_TX_LENGTH]    = 32'd15;
      end
      2: begin
        cfg_vals[REG_RX_LENGTH] = '0;
        cfg_vals[REG_TX_LENGTH] = '0;
        cfg_vals[REG_ROUTE_IDS] = '0;
      end
      5: cfg_vals[REG_ROUTE_IDS] = '1;
      6: cfg_vals[REG_SIGNAL_COUNT] = '0;
      default: ;
    endcase
  endfunction

  // random item, steered toward matching routes, handle 0 and known ids
  task automatic push_random();
    op_t op;
    logic [15:0] pdu;
    logic [15:0] plen;
    logic [7:0]  sid;
    int r;
    pdu  = 16'($urandom_range(65535));
    plen = ($urandom_range(99) < 70) ? 16'($urandom_range(9)) : 16'($urandom_range(65535));
    sid  = 8'($urandom_range(255));
    r = $urandom_range(99);
    if (r < 15) begin
      op = OP_RECEIVE;
      if ($urandom_range(99) < 85) pdu = board.routes[15:0];
    end else if (r < 50) begin
      op = OP_READ;
    end else if (r < 85) begin
      op = OP_WRITE;
    end else begin
      op = OP_SEND;
      if ($urandom_range(99) < 80) pdu = '0;
    end
    if ($urandom_range(99) < 80) sid = board.sig_desc[$urandom_range(DESC_REGS - 1)][7:0];
    push_item(op, pdu, plen, {$urandom(), $urandom()}, sid, $urandom());
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    board = new();
    board.clear();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: no descriptors searched, both routes zero
    push_item(OP_READ, '0, '0, '0, 8'h00, '0);
    push_item(OP_RECEIVE, 16'h0000, 16'hFFFF, '1, 8'hFF, '1);
    push_item(OP_SEND, 16'h0000, '0, '0, '0, '0);
    drain();

    // wrap-around field, size zero field, full 32-bit field
    cfg_vals[REG_SIGNAL_COUNT]  = 32'(DESC_REGS);
    cfg_vals[REG_DESC_BASE]     = make_desc(8'h00, 6'd0, 6'd32, 1'b1);
    cfg_vals[REG_DESC_BASE + 1] = make_desc(8'hFF, 6'd63, 6'd1, 1'b0);
    cfg_vals[REG_DESC_BASE + 2] = make_desc(8'h5A, 6'd60, 6'd8, 1'b0);
    cfg_vals[REG_DESC_BASE + 3] = make_desc(8'h33, 6'd37, 6'd0, 1'b1);
    cfg_vals[REG_ROUTE_IDS]     = 32'hABCD_1234;
    cfg_vals[REG_RX_LENGTH]     = 32'd15;
    cfg_vals[REG_TX_LENGTH]     = 32'd8;
    program_regs();
    push_item(OP_RECEIVE, 16'h1234, 16'd3, 64'h0123_4567_89AB_CDEF, '0, '0);
    push_item(OP_RECEIVE, 16'h1235, 16'd8, '0, '0, '0);
    push_item(OP_READ, '0, '0, '0, 8'h00, '0);
    push_item(OP_READ, '0, '0, '0, 8'hFF, '0);
    push_item(OP_READ, '0, '0, '0, 8'h5A, '0);
    push_item(OP_READ, '0, '0, '0, 8'h33, '0);
    push_item(OP_READ, '0, '0, '0, 8'h77, '0);
    push_item(OP_WRITE, '0, '0, '0, 8'h00, '1);
    push_item(OP_WRITE, '0, '0, '0, 8'hFF, '0);
    push_item(OP_WRITE, '0, '0, '0, 8'h5A, 32'h0000_00A5);
    push_item(OP_WRITE, '0, '0, '0, 8'h33, '1);
    push_item(OP_WRITE, '0, '0, '0, 8'h77, '1);
    push_item(OP_SEND, 16'h0000, '0, '0, '0, '0);
    push_item(OP_SEND, 16'hFFFF, '0, '0, '0, '0);
    drain();

    // count past the table, duplicate id, oversize field, zero-length copy
    cfg_vals[REG_SIGNAL_COUNT]  = 32'd7;
    cfg_vals[REG_DESC_BASE + 2] = make_desc(8'h00, 6'd5, 6'd12, 1'b0);
    cfg_vals[REG_DESC_BASE + 3] = make_desc(8'h33, 6'd50, 6'd63, 1'b1);
    cfg_vals[REG_ROUTE_IDS]     = 32'hFFFF_FFFF;
    cfg_vals[REG_RX_LENGTH]     = 32'd0;
    cfg_vals[REG_TX_LENGTH]     = 32'd15;
    program_regs();
    push_item(OP_READ, '0, '0, '0, 8'h33, '0);
    push_item(OP_WRITE, '0, '0, '0, 8'h33, '1);
    push_item(OP_SEND, 16'h0000, '0, '0, '0, '0);
    push_item(OP_RECEIVE, 16'hFFFF, 16'd8, '0, '0, '0);
    push_item(OP_READ, '0, '0, '0, 8'h00, '0);
    drain();

    // random phases: none, sender idle, receiver stall, both
    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      pick_config(phase);
      program_regs();
      case (phase % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 50; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 50; end
        default: begin send_idle_pct = 16; recv_stall_pct = 16; end
      endcase
      // long receiver hold-off so the core backs up and stalls its input
      if (phase == 4) hold_cycles = LONG_HOLD;
      for (int n = 0; n < ITEMS_PER_PHASE; n++) push_random();
      drain();
    end

    repeat (20) @(posedge clk);
    if (board.expected_q.size() != 0) begin
      $error("%0d predicted results never arrived", board.expected_q.size());
      board.errors++;
    end
    if (board.errors == 0) begin
      $display("can_signal_pack_unpack_core_tb: PASS");
    end else begin
      $display("can_signal_pack_unpack_core_tb: FAIL");
    end
    $finish;
  end

endmodule
